FILE: src/wlmm_pkg.sv
`default_nettype none
package wlmm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int ROW_LIMIT  = 1024;
    localparam int MAX_RADIUS = 3;
    localparam int SCORE_BITS = 16;

    localparam int SLOTS     = 2 * MAX_RADIUS + 2;
    localparam int LANE_BITS = $clog2(SLOTS);
    localparam int TAPS      = 2 * MAX_RADIUS + 1;
    localparam int TAP_BITS  = $clog2(TAPS);
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ROW_BITS  = $clog2(ROW_LIMIT);
    localparam int DIM_BITS  = 11;
    localparam int SDIM_BITS = DIM_BITS + 1;
    localparam int CFG_RAD_BITS = 2;
    localparam int RAD_BITS  = $clog2(MAX_RADIUS + 1);
    localparam int D_BITS    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

    localparam int NUM_REGS      = 4;
    localparam int REG_IDX_BITS  = $clog2(NUM_REGS);
    localparam int ADDR_BITS     = REG_IDX_BITS + 2;
    localparam int APB_DATA_BITS = 32;

    localparam logic [DIM_BITS-1:0]     RST_WIDTH  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0]     RST_HEIGHT = DIM_BITS'(480);
    localparam logic [CFG_RAD_BITS-1:0] RST_RADIUS = CFG_RAD_BITS'(1);
    localparam logic [SCORE_BITS-1:0]   RST_MIN    = SCORE_BITS'(256);

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_WINDOW_RADIUS,
        REG_MIN_SCORE
    } reg_idx_t;

    typedef logic [SLOTS-1:0][SCORE_BITS-1:0] lanes_t;

    typedef struct packed {
        logic                  en;
        logic [LANE_BITS-1:0]  lane;
        logic [SCORE_BITS-1:0] data;
    } ls_wr_t;

    typedef struct packed {
        logic                  emit;
        logic                  last;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic [RAD_BITS-1:0]   rad;
        logic [TAPS-1:0]       hmask;
        logic [SLOTS-1:0]      vmask;
        logic [LANE_BITS-1:0]  clane;
        ls_wr_t                wr;
    } s1_t;

    typedef struct packed {
        logic                  emit;
        logic                  last;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic [RAD_BITS-1:0]   rad;
        logic [TAPS-1:0]       hmask;
        logic [SCORE_BITS-1:0] colmax;
        logic [SCORE_BITS-1:0] center;
    } s2_t;

    typedef struct packed {
        logic                is_corner;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last;
    } res_t;

    function automatic logic [DIM_BITS-1:0] clamp_dim(
        input logic [DIM_BITS-1:0] v,
        input logic [DIM_BITS-1:0] hi
    );
        logic [DIM_BITS-1:0] r;
        if (v == '0)
        begin
            r = DIM_BITS'(1);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [RAD_BITS-1:0] clamp_rad(input logic [CFG_RAD_BITS-1:0] v);
        logic [RAD_BITS-1:0] r;
        if (int'(v) > MAX_RADIUS)
        begin
            r = RAD_BITS'(MAX_RADIUS);
        end
        else
        begin
            r = RAD_BITS'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/wlmm_line_store.sv
`default_nettype none
module wlmm_line_store
    import wlmm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rd_en,
    input  wire logic [COL_BITS-1:0] addr,
    input  wire ls_wr_t              wr,
    output      lanes_t              rd_data
);

    // one word per column, one lane per row slot
    lanes_t store_mem [MAX_WIDTH];
    lanes_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[addr][wr.lane] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: src/window_local_max_marker_top.sv
`default_nettype none
// channel   | handshake                      | payload
// ----------+--------------------------------+------------------------------
// score in  | score_valid / score_ready      | score[15:0], pad
// mark out  | mark_valid / mark_ready        | is_corner, row[9:0], col[9:0], last
// config    | psel, penable, pwrite, pready  | paddr[3:0], pwdata, prdata
//
// One beat per cycle while the output buffer has room. A beat is registered
// at line store read, column max and window compare. The line store has one
// read and one write port on the same column, so every beat takes one slot.
// Reset clears counters and valids and sets config defaults, not the line store.
// A two-entry output buffer absorbs stalls; score_ready drops only when full.
module window_local_max_marker_top
    import wlmm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_BITS-1:0]     paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output      logic [APB_DATA_BITS-1:0] prdata,
    output      logic                     pready,
    input  wire logic                     score_valid,
    output      logic                     score_ready,
    input  wire logic [SCORE_BITS-1:0]    score,
    input  wire logic                     pad,
    output      logic                     mark_valid,
    input  wire logic                     mark_ready,
    output      logic                     is_corner,
    output      logic [ROW_BITS-1:0]      row,
    output      logic [COL_BITS-1:0]      col,
    output      logic                     last
);

    logic [DIM_BITS-1:0]     cfg_w_reg, cfg_w_next;
    logic [DIM_BITS-1:0]     cfg_h_reg, cfg_h_next;
    logic [CFG_RAD_BITS-1:0] cfg_r_reg, cfg_r_next;
    logic [SCORE_BITS-1:0]   cfg_min_reg, cfg_min_next;

    logic [DIM_BITS-1:0] act_w_reg, act_w_next;
    logic [DIM_BITS-1:0] act_h_reg, act_h_next;
    logic [RAD_BITS-1:0] act_r_reg, act_r_next;

    logic [DIM_BITS-1:0] in_row_reg, in_row_next;
    logic [COL_BITS-1:0] in_col_reg, in_col_next;
    logic [D_BITS-1:0]   pre_cnt_reg, pre_cnt_next;
    logic [ROW_BITS-1:0] jr_reg, jr_next;
    logic [COL_BITS-1:0] jc_reg, jc_next;

    logic s1_v_reg, s1_v_next;
    s1_t  s1_reg, s1_next;
    logic s2_v_reg, s2_v_next;
    s2_t  s2_reg, s2_next;

    logic [SCORE_BITS-1:0] cm_reg [TAPS-1];
    logic [SCORE_BITS-1:0] ct_reg [TAPS-1];

    logic out_v_reg, out_v_next;
    res_t out_reg, out_next;
    logic skid_v_reg, skid_v_next;
    res_t skid_reg, skid_next;

    logic                  apb_wr;
    reg_idx_t              reg_idx;
    logic                  adv;
    logic                  fire;
    logic                  start;
    logic [DIM_BITS-1:0]   g_w;
    logic [DIM_BITS-1:0]   g_h;
    logic [RAD_BITS-1:0]   g_r;
    logic                  in_pix;
    logic                  active;
    logic [D_BITS-1:0]     dly;
    logic                  emit;
    logic                  is_last;
    lanes_t                rd_lanes;
    lanes_t                lanes;
    logic [SCORE_BITS-1:0] colmax;
    logic [SCORE_BITS-1:0] win_max;
    logic [SCORE_BITS-1:0] cur;
    res_t                  res;
    logic                  res_v;

    assign apb_wr  = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:   prdata = APB_DATA_BITS'(cfg_w_reg);
            REG_FRAME_HEIGHT:  prdata = APB_DATA_BITS'(cfg_h_reg);
            REG_WINDOW_RADIUS: prdata = APB_DATA_BITS'(cfg_r_reg);
            REG_MIN_SCORE:     prdata = APB_DATA_BITS'(cfg_min_reg);
        endcase
    end

    always_comb
    begin
        cfg_w_next   = cfg_w_reg;
        cfg_h_next   = cfg_h_reg;
        cfg_r_next   = cfg_r_reg;
        cfg_min_next = cfg_min_reg;
        if (apb_wr)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:   cfg_w_next   = pwdata[DIM_BITS-1:0];
                REG_FRAME_HEIGHT:  cfg_h_next   = pwdata[DIM_BITS-1:0];
                REG_WINDOW_RADIUS: cfg_r_next   = pwdata[CFG_RAD_BITS-1:0];
                REG_MIN_SCORE:     cfg_min_next = pwdata[SCORE_BITS-1:0];
            endcase
        end
    end

    assign adv         = !skid_v_reg;
    assign score_ready = adv;
    assign fire        = score_valid && score_ready;

    // geometry of this beat: freshly latched on the first pixel of a frame
    always_comb
    begin
        logic [D_BITS-1:0] r_ext;
        logic [D_BITS-1:0] w_ext;
        start = (in_row_reg == '0) && (in_col_reg == '0);
        g_w = start ? clamp_dim(cfg_w_reg, DIM_BITS'(MAX_WIDTH)) : act_w_reg;
        g_h = start ? clamp_dim(cfg_h_reg, DIM_BITS'(ROW_LIMIT)) : act_h_reg;
        g_r = start ? clamp_rad(cfg_r_reg) : act_r_reg;
        r_ext   = D_BITS'(g_r);
        w_ext   = D_BITS'(g_w);
        dly     = r_ext * w_ext + r_ext;
        in_pix  = in_row_reg < g_h;
        active  = !(pad && in_pix);
        emit    = pre_cnt_reg >= dly;
        is_last = emit && (DIM_BITS'(jr_reg) == g_h - DIM_BITS'(1))
                       && (DIM_BITS'(jc_reg) == g_w - DIM_BITS'(1));
    end

    always_comb
    begin
        logic [DIM_BITS-1:0] col_inc;
        logic [DIM_BITS-1:0] jc_inc;
        act_w_next   = act_w_reg;
        act_h_next   = act_h_reg;
        act_r_next   = act_r_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        pre_cnt_next = pre_cnt_reg;
        jr_next      = jr_reg;
        jc_next      = jc_reg;
        col_inc      = DIM_BITS'(in_col_reg) + DIM_BITS'(1);
        jc_inc       = DIM_BITS'(jc_reg) + DIM_BITS'(1);
        if (fire && active)
        begin
            if (start)
            begin
                act_w_next = g_w;
                act_h_next = g_h;
                act_r_next = g_r;
            end
            if (col_inc >= g_w)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + DIM_BITS'(1);
            end
            else
            begin
                in_col_next = col_inc[COL_BITS-1:0];
            end
            if (!emit)
            begin
                pre_cnt_next = pre_cnt_reg + D_BITS'(1);
            end
            else if (jc_inc >= g_w)
            begin
                jc_next = '0;
                jr_next = jr_reg + ROW_BITS'(1);
            end
            else
            begin
                jc_next = jc_inc[COL_BITS-1:0];
            end
            if (is_last)
            begin
                in_row_next  = '0;
                in_col_next  = '0;
                pre_cnt_next = '0;
                jr_next      = '0;
                jc_next      = '0;
            end
        end
    end

    // stage 0: masks for the rows and columns the window may touch
    always_comb
    begin
        logic signed [SDIM_BITS-1:0] lo_s;
        logic signed [SDIM_BITS-1:0] row_s;
        logic [LANE_BITS-1:0]        off;
        logic [DIM_BITS-1:0]         room_r;
        logic [RAD_BITS-1:0]         ra;
        logic [RAD_BITS-1:0]         lb;
        logic [TAP_BITS-1:0]         kmin;
        logic [TAP_BITS-1:0]         kmax;
        s1_next = '0;
        // rows in_row-2r .. in_row around fetch center in_row-r
        lo_s = $signed({1'b0, in_row_reg}) - $signed(SDIM_BITS'({g_r, 1'b0}));
        for (int s = 0; s < SLOTS; s++)
        begin
            off   = LANE_BITS'(s) - lo_s[LANE_BITS-1:0];
            row_s = lo_s + $signed(SDIM_BITS'(off));
            s1_next.vmask[s] = (SDIM_BITS'(off) <= SDIM_BITS'({g_r, 1'b0}))
                && (row_s >= 0) && (row_s < $signed({1'b0, g_h}));
        end
        room_r = g_w - DIM_BITS'(1) - DIM_BITS'(jc_reg);
        ra     = (room_r < DIM_BITS'(g_r)) ? RAD_BITS'(room_r) : g_r;
        lb     = (DIM_BITS'(jc_reg) < DIM_BITS'(g_r)) ? RAD_BITS'(jc_reg) : g_r;
        kmin   = TAP_BITS'(g_r) - TAP_BITS'(ra);
        kmax   = TAP_BITS'(g_r) + TAP_BITS'(lb);
        for (int k = 0; k < TAPS; k++)
        begin
            s1_next.hmask[k] = (TAP_BITS'(k) >= kmin) && (TAP_BITS'(k) <= kmax);
        end
        s1_next.emit    = emit;
        s1_next.last    = is_last;
        s1_next.row     = jr_reg;
        s1_next.col     = jc_reg;
        s1_next.rad     = g_r;
        s1_next.clane   = in_row_reg[LANE_BITS-1:0] - LANE_BITS'(g_r);
        s1_next.wr.en   = fire && active && in_pix;
        s1_next.wr.lane = in_row_reg[LANE_BITS-1:0];
        s1_next.wr.data = score;
        s1_v_next       = fire && active;
    end

    wlmm_line_store u_store (
        .clk     (clk),
        .rd_en   (adv),
        .addr    (in_col_reg),
        .wr      (s1_next.wr),
        .rd_data (rd_lanes)
    );

    // stage 1: forward this beat's own write, then column max
    always_comb
    begin
        lanes = rd_lanes;
        if (s1_reg.wr.en)
        begin
            lanes[s1_reg.wr.lane] = s1_reg.wr.data;
        end
        colmax = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (s1_reg.vmask[s] && (lanes[s] > colmax))
            begin
                colmax = lanes[s];
            end
        end
        s2_next.emit   = s1_reg.emit;
        s2_next.last   = s1_reg.last;
        s2_next.row    = s1_reg.row;
        s2_next.col    = s1_reg.col;
        s2_next.rad    = s1_reg.rad;
        s2_next.hmask  = s1_reg.hmask;
        s2_next.colmax = colmax;
        s2_next.center = lanes[s1_reg.clane];
        s2_v_next      = s1_v_reg;
    end

    // stage 2: tap k holds the column fetched k beats ago
    always_comb
    begin
        logic [SCORE_BITS-1:0] cv [TAPS];
        logic [SCORE_BITS-1:0] tv [TAPS];
        cv[0] = s2_reg.colmax;
        tv[0] = s2_reg.center;
        for (int k = 1; k < TAPS; k++)
        begin
            cv[k] = cm_reg[k-1];
            tv[k] = ct_reg[k-1];
        end
        cur     = tv[TAP_BITS'(s2_reg.rad)];
        win_max = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            if (s2_reg.hmask[k] && (cv[k] > win_max))
            begin
                win_max = cv[k];
            end
        end
        res.is_corner = (cur >= cfg_min_reg) && (cur >= win_max);
        res.row       = s2_reg.row;
        res.col       = s2_reg.col;
        res.last      = s2_reg.last;
        res_v         = adv && s2_v_reg && s2_reg.emit;
    end

    always_comb
    begin
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        skid_v_next = skid_v_reg;
        skid_next   = skid_reg;
        priority if (out_v_reg && mark_ready)
        begin
            if (skid_v_reg)
            begin
                out_next    = skid_reg;
                skid_v_next = 1'b0;
            end
            else
            begin
                out_v_next = res_v;
                out_next   = res;
            end
        end
        else if (!out_v_reg)
        begin
            out_v_next = res_v;
            out_next   = res;
        end
        else if (res_v)
        begin
            skid_v_next = 1'b1;
            skid_next   = res;
        end
    end

    assign mark_valid = out_v_reg;
    assign is_corner  = out_reg.is_corner;
    assign row        = out_reg.row;
    assign col        = out_reg.col;
    assign last       = out_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg   <= RST_WIDTH;
            cfg_h_reg   <= RST_HEIGHT;
            cfg_r_reg   <= RST_RADIUS;
            cfg_min_reg <= RST_MIN;
            act_w_reg   <= RST_WIDTH;
            act_h_reg   <= RST_HEIGHT;
            act_r_reg   <= clamp_rad(RST_RADIUS);
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            pre_cnt_reg <= '0;
            jr_reg      <= '0;
            jc_reg      <= '0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
            skid_v_reg  <= 1'b0;
        end
        else
        begin
            cfg_w_reg   <= cfg_w_next;
            cfg_h_reg   <= cfg_h_next;
            cfg_r_reg   <= cfg_r_next;
            cfg_min_reg <= cfg_min_next;
            act_w_reg   <= act_w_next;
            act_h_reg   <= act_h_next;
            act_r_reg   <= act_r_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            pre_cnt_reg <= pre_cnt_next;
            jr_reg      <= jr_next;
            jc_reg      <= jc_next;
            if (adv)
            begin
                s1_v_reg <= s1_v_next;
                s2_v_reg <= s2_v_next;
            end
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            if (s2_v_reg)
            begin
                cm_reg[0] <= s2_reg.colmax;
                ct_reg[0] <= s2_reg.center;
                for (int k = 1; k < TAPS - 1; k++)
                begin
                    cm_reg[k] <= cm_reg[k-1];
                    ct_reg[k] <= ct_reg[k-1];
                end
            end
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid holds a beat while output register is empty");

    a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && active && is_last) |=>
            (in_row_reg == '0) && (in_col_reg == '0) && (pre_cnt_reg == '0))
        else $error("frame counters not cleared after last mark");

    a_pre_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pre_cnt_reg <= dly)
        else $error("startup counter ran past the window delay");

    // a one-pixel-wide frame runs the flush tail 2r rows past the last row
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> (SDIM_BITS'(in_row_reg)
            <= SDIM_BITS'(act_h_reg) + SDIM_BITS'(act_r_reg) + SDIM_BITS'(act_r_reg)))
        else $error("input row ran past the flush tail");

endmodule
`default_nettype wire
